// ===== design/cbag_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbag_pkg
// Shared types, widths, constants and tables of the chain bond/angle unit.
// ----------------------------------------------------------------------------
package cbag_pkg;

	localparam int POS_W     = 24;
	localparam int LEN_W     = 24;
	localparam int ANG_W     = 16;
	localparam int BOX_W     = 23;
	localparam int CHAIN_W   = 7;
	localparam int IDX_W     = 6;
	localparam int VEC_W     = 25;
	localparam int REM_W     = 23;
	localparam int MUL_W     = 27;
	localparam int PROD_W    = 54;
	localparam int SQ_W      = 52;
	localparam int ROOT_W    = 26;
	localparam int MAG_W     = 53;
	localparam int COS_W     = 25;
	localparam int COR_W     = 27;
	localparam int Z_W       = 24;
	localparam int TH_W      = 25;
	localparam int BSUM_W    = 30;
	localparam int ASUM_W    = 22;
	localparam int DIV_W     = 30;
	localparam int DEN_W     = 6;
	localparam int CNT_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam int WRAP_STEPS = 25;
	localparam int SQRT_STEPS = 26;
	localparam int COS_STEPS  = 24;
	localparam int COR_STEPS  = 20;
	localparam int DIV_STEPS  = 30;

	localparam logic [LEN_W-1:0]   LEN_MAX     = 24'hFF_FFFF;
	localparam logic [ANG_W-1:0]   ANGLE_MAX   = 16'd51472;
	localparam logic [TH_W-1:0]    PI_Q20      = 25'd3294199;
	localparam logic [CHAIN_W-1:0] CHAIN_MIN   = 7'd3;
	localparam logic [CHAIN_W-1:0] CHAIN_MAX   = 7'd64;
	localparam logic [BOX_W-1:0]   BOX_RESET   = 23'd491520;
	localparam logic [CHAIN_W-1:0] CHAIN_RESET = 7'd16;
	localparam logic [SQ_W-1:0]    SINE_ONE    = 52'h1_0000_0000_0000;
	localparam logic [SQ_W-1:0]    SQ_BIT_TOP  = 52'h4_0000_0000_0000;
	localparam logic [COS_W-1:0]   COS_ONE     = 25'h100_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_BOX   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAIN = 1'b1;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
	} bead_t;

	typedef struct packed {
		logic [LEN_W-1:0] bond_length;
		logic             bond_valid;
		logic [ANG_W-1:0] bend_angle;
		logic             angle_valid;
		logic             degenerate;
		logic             chain_done;
		logic [LEN_W-1:0] end_to_end;
		logic [LEN_W-1:0] mean_bond_length;
		logic [ANG_W-1:0] mean_bend_angle;
	} geom_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_WSTART, OP_WSTEP, OP_WEND, OP_MUL_NORM, OP_MUL_DOT,
		OP_MUL_PROD, OP_MUL_CSQ, OP_SQ_START, OP_SQ_STEP, OP_BEND, OP_DEGEN,
		OP_COS_START, OP_COS_STEP, OP_COS_END, OP_COR_START, OP_COR_STEP,
		OP_AEND, OP_UPDATE, OP_EEND, OP_DV_START, OP_DV_STEP, OP_DV_END, OP_PUB
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_WSTART, S_WSTEP, S_WEND, S_NMUL, S_NWAIT, S_SQSTART, S_SQSTEP,
		S_BEND, S_ACHK, S_DEGEN, S_DMUL, S_DWAIT, S_PROD, S_PWAIT, S_CSTART,
		S_CSTEP, S_CEND, S_CSQ, S_CWAIT, S_CORSTART, S_CORSTEP, S_AEND, S_UPDATE,
		S_EEND, S_DVSTART, S_DVSTEP, S_DVEND, S_PUB
	} state_t;

	typedef struct packed {
		op_t              op;
		logic [CNT_W-1:0] cnt;
		logic             alt;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic angle_en;
		logic last;
		logic degen;
		logic out_busy;
	} status_t;

	function automatic logic [19:0] atan_q20(input logic [CNT_W-1:0] i);
		logic [19:0] r;
		case (i)
			5'd0:  r = 20'd823550;
			5'd1:  r = 20'd486170;
			5'd2:  r = 20'd256879;
			5'd3:  r = 20'd130396;
			5'd4:  r = 20'd65451;
			5'd5:  r = 20'd32757;
			5'd6:  r = 20'd16383;
			5'd7:  r = 20'd8192;
			5'd8:  r = 20'd4096;
			5'd9:  r = 20'd2048;
			5'd10: r = 20'd1024;
			5'd11: r = 20'd512;
			5'd12: r = 20'd256;
			5'd13: r = 20'd128;
			5'd14: r = 20'd64;
			5'd15: r = 20'd32;
			5'd16: r = 20'd16;
			5'd17: r = 20'd8;
			5'd18: r = 20'd4;
			5'd19: r = 20'd2;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] sat_len(input logic [SQ_W-1:0] v);
		return (|v[SQ_W-1:LEN_W]) ? LEN_MAX : v[LEN_W-1:0];
	endfunction

endpackage

// ===== design/cbag_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbag_ctrl
// Sequencer: steps the datapath through wrap, square root, cosine, CORDIC
// and mean division, as each bead request needs them.
// ----------------------------------------------------------------------------
module cbag_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  cbag_pkg::status_t st,
	output cbag_pkg::cmd_t    cmd
);
	import cbag_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             e2e_q, e2e_d;
	logic             sine_q, sine_d;
	logic             dv_q, dv_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			e2e_q   <= 1'b0;
			sine_q  <= 1'b0;
			dv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			e2e_q   <= e2e_d;
			sine_q  <= sine_d;
			dv_q    <= dv_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		e2e_d   = e2e_q;
		sine_d  = sine_q;
		dv_d    = dv_q;
		cmd     = '{op: OP_NONE, cnt: cnt_q, alt: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					e2e_d   = 1'b0;
					sine_d  = 1'b0;
					dv_d    = 1'b0;
					state_d = st.first ? S_PUB : S_WSTART;
				end
			end
			S_WSTART: begin
				cmd.op  = OP_WSTART;
				cmd.alt = e2e_q;
				cnt_d   = '0;
				state_d = S_WSTEP;
			end
			S_WSTEP: begin
				cmd.op = OP_WSTEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WRAP_STEPS - 1)) state_d = S_WEND;
			end
			S_WEND: begin
				cmd.op  = OP_WEND;
				cnt_d   = '0;
				state_d = S_NMUL;
			end
			S_NMUL: begin
				cmd.op = OP_MUL_NORM;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(2)) state_d = S_NWAIT;
			end
			S_NWAIT: state_d = S_SQSTART;
			S_SQSTART: begin
				cmd.op  = OP_SQ_START;
				cmd.alt = sine_q;
				cnt_d   = '0;
				state_d = S_SQSTEP;
			end
			S_SQSTEP: begin
				cmd.op = OP_SQ_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
					if (sine_q) state_d = S_CORSTART;
					else if (e2e_q) state_d = S_EEND;
					else state_d = S_BEND;
				end
			end
			S_BEND: begin
				cmd.op  = OP_BEND;
				state_d = st.angle_en ? S_ACHK : S_UPDATE;
			end
			S_ACHK: begin
				cnt_d   = '0;
				state_d = st.degen ? S_DEGEN : S_DMUL;
			end
			S_DEGEN: begin
				cmd.op  = OP_DEGEN;
				state_d = S_UPDATE;
			end
			S_DMUL: begin
				cmd.op = OP_MUL_DOT;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(2)) state_d = S_DWAIT;
			end
			S_DWAIT: state_d = S_PROD;
			S_PROD: begin
				cmd.op  = OP_MUL_PROD;
				state_d = S_PWAIT;
			end
			S_PWAIT: state_d = S_CSTART;
			S_CSTART: begin
				cmd.op  = OP_COS_START;
				cnt_d   = '0;
				state_d = S_CSTEP;
			end
			S_CSTEP: begin
				cmd.op = OP_COS_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(COS_STEPS - 1)) state_d = S_CEND;
			end
			S_CEND: begin
				cmd.op  = OP_COS_END;
				state_d = S_CSQ;
			end
			S_CSQ: begin
				cmd.op  = OP_MUL_CSQ;
				cmd.cnt = '0;
				state_d = S_CWAIT;
			end
			S_CWAIT: begin
				sine_d  = 1'b1;
				state_d = S_SQSTART;
			end
			S_CORSTART: begin
				cmd.op  = OP_COR_START;
				cnt_d   = '0;
				state_d = S_CORSTEP;
			end
			S_CORSTEP: begin
				cmd.op = OP_COR_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(COR_STEPS - 1)) state_d = S_AEND;
			end
			S_AEND: begin
				cmd.op  = OP_AEND;
				sine_d  = 1'b0;
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.op = OP_UPDATE;
				if (st.last) begin
					e2e_d   = 1'b1;
					state_d = S_WSTART;
				end else begin
					state_d = S_PUB;
				end
			end
			S_EEND: begin
				cmd.op  = OP_EEND;
				dv_d    = 1'b0;
				state_d = S_DVSTART;
			end
			S_DVSTART: begin
				cmd.op  = OP_DV_START;
				cmd.alt = dv_q;
				cnt_d   = '0;
				state_d = S_DVSTEP;
			end
			S_DVSTEP: begin
				cmd.op = OP_DV_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_DVEND;
			end
			S_DVEND: begin
				cmd.op  = OP_DV_END;
				cmd.alt = dv_q;
				dv_d    = 1'b1;
				state_d = dv_q ? S_PUB : S_DVSTART;
			end
			S_PUB: begin
				if (!st.out_busy) begin
					cmd.op  = OP_PUB;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== design/cbag_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbag_dp
// Datapath: config registers, bead state, three wrap lanes, multiplier
// with accumulator, shift-subtract square root and dividers, CORDIC.
// ----------------------------------------------------------------------------
module cbag_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cbag_pkg::cmd_t                    cmd,
	output cbag_pkg::status_t                 st,
	input  cbag_pkg::bead_t                   in_data,
	input  logic                              cfg_we,
	input  logic [cbag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbag_pkg::BOX_W-1:0]        cfg_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output cbag_pkg::geom_t                   out_data
);
	import cbag_pkg::*;

	// control state
	logic [BOX_W-1:0]   box_q;
	logic [CHAIN_W-1:0] chain_q;
	logic [IDX_W-1:0]   idx_q;
	logic               ov_q;
	logic               add_s1, prodf_s1;

	// payload
	logic signed [POS_W-1:0] p_q [3];
	logic signed [POS_W-1:0] first_q [3];
	logic signed [POS_W-1:0] prev_q [3];
	logic signed [VEC_W-1:0] d_q [3];
	logic [VEC_W-1:0]        wa_q [3];
	logic [REM_W-1:0]        wr_q [3];
	logic signed [VEC_W-1:0] v_q [3];
	logic signed [VEC_W-1:0] pv_q [3];
	logic [CHAIN_W-1:0]      len_q;
	logic signed [PROD_W-1:0] mul_s1, acc_q;
	logic [SQ_W-1:0]         prod_q;
	logic [SQ_W-1:0]         sv_q, sres_q, sbit_q;
	logic [ROOT_W-1:0]       rootc_q, rootp_q;
	logic [MAG_W-1:0]        mag_q;
	logic [COS_W-1:0]        c_q;
	logic                    clamp_q, neg_q;
	logic signed [COR_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0]   z_q;
	logic [BSUM_W-1:0]       bls_q;
	logic [ASUM_W-1:0]       as_q;
	logic [DIV_W-1:0]        dn_q, dq_q;
	logic [DEN_W-1:0]        dr_q, den_q;
	geom_t                   wres_q, out_q;

	// combinational
	logic signed [VEC_W-1:0] dnew [3];
	logic [VEC_W-1:0]        dabs [3];
	logic [REM_W:0]          wt [3];
	logic [REM_W:0]          wn [3];
	logic signed [VEC_W-1:0] rr [3];
	logic signed [VEC_W-1:0] vnew [3];
	logic signed [MUL_W-1:0] ma, mb;
	logic signed [PROD_W-1:0] mprod;
	logic [1:0]              lane;
	logic [SQ_W-1:0]         sq_try;
	logic [MAG_W-1:0]        m2, mabs;
	logic signed [COR_W-1:0] xs, ys;
	logic signed [Z_W-1:0]   at;
	logic signed [TH_W-1:0]  th, thc;
	logic [TH_W-1:0]         thr;
	logic [ANG_W-1:0]        ang;
	logic [DEN_W:0]          dt;
	logic [CHAIN_W-1:0]      len_c;

	assign lane = cmd.cnt[1:0];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dnew[k] = cmd.alt ? (VEC_W'(p_q[k]) - VEC_W'(first_q[k]))
			                  : (VEC_W'(p_q[k]) - VEC_W'(prev_q[k]));
			dabs[k] = dnew[k][VEC_W-1] ? VEC_W'(-dnew[k]) : VEC_W'(dnew[k]);
			wt[k]   = {wr_q[k], wa_q[k][VEC_W-1]};
			wn[k]   = (wt[k] >= {1'b0, box_q}) ? (wt[k] - {1'b0, box_q}) : wt[k];
			// round half away from zero: big remainder folds to negative side
			rr[k]   = ({wr_q[k], 1'b0} >= {1'b0, box_q})
			          ? ($signed({2'b00, wr_q[k]}) - $signed({2'b00, box_q}))
			          : $signed({2'b00, wr_q[k]});
			if (box_q == '0) vnew[k] = d_q[k];
			else vnew[k] = d_q[k][VEC_W-1] ? -rr[k] : rr[k];
		end
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_MUL_NORM: begin
				ma = MUL_W'(v_q[lane]);
				mb = MUL_W'(v_q[lane]);
			end
			OP_MUL_DOT: begin
				ma = MUL_W'(pv_q[lane]);
				mb = MUL_W'(v_q[lane]);
			end
			OP_MUL_PROD: begin
				ma = $signed({1'b0, rootp_q});
				mb = $signed({1'b0, rootc_q});
			end
			OP_MUL_CSQ: begin
				ma = $signed({2'b00, c_q});
				mb = $signed({2'b00, c_q});
			end
			default: ;
		endcase
		mprod = ma * mb;
	end

	always_comb begin
		sq_try = sres_q + sbit_q;
		m2     = {mag_q[MAG_W-2:0], 1'b0};
		mabs   = acc_q[PROD_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
		xs     = x_q >>> cmd.cnt;
		ys     = y_q >>> cmd.cnt;
		at     = $signed({4'b0000, atan_q20(cmd.cnt)});
		th     = neg_q ? ($signed(PI_Q20) - TH_W'(z_q)) : TH_W'(z_q);
		thc    = th[TH_W-1] ? '0 : th;
		thr    = (TH_W'(thc) + TH_W'(32)) >> 6;
		ang    = (thr > TH_W'(ANGLE_MAX)) ? ANGLE_MAX : thr[ANG_W-1:0];
		dt     = {dr_q, dn_q[DIV_W-1]};
		if (chain_q < CHAIN_MIN) len_c = CHAIN_MIN;
		else if (chain_q > CHAIN_MAX) len_c = CHAIN_MAX;
		else len_c = chain_q;
	end

	assign st.first    = (idx_q == '0);
	assign st.angle_en = (idx_q >= IDX_W'(2));
	assign st.last     = ({1'b0, idx_q} >= (len_q - 1'b1));
	assign st.degen    = (rootc_q == '0) || (rootp_q == '0);
	assign st.out_busy = ov_q && out_stall;

	assign out_valid = ov_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q    <= BOX_RESET;
			chain_q  <= CHAIN_RESET;
			idx_q    <= '0;
			ov_q     <= 1'b0;
			add_s1   <= 1'b0;
			prodf_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BOX:   box_q   <= cfg_data;
					CFG_CHAIN: chain_q <= cfg_data[CHAIN_W-1:0];
					default: ;
				endcase
			end
			add_s1   <= (cmd.op == OP_MUL_NORM) || (cmd.op == OP_MUL_DOT) ||
			            (cmd.op == OP_MUL_CSQ);
			prodf_s1 <= (cmd.op == OP_MUL_PROD);
			if (cmd.op == OP_PUB) ov_q <= 1'b1;
			else if (ov_q && !out_stall) ov_q <= 1'b0;
			if (cmd.op == OP_LOAD && idx_q == '0) idx_q <= IDX_W'(1);
			else if (cmd.op == OP_UPDATE) idx_q <= st.last ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		mul_s1 <= mprod;
		if (add_s1) acc_q <= acc_q + mul_s1;
		if (prodf_s1) prod_q <= mul_s1[SQ_W-1:0];
		unique case (cmd.op)
			OP_LOAD: begin
				p_q[0] <= in_data.pos_x;
				p_q[1] <= in_data.pos_y;
				p_q[2] <= in_data.pos_z;
				wres_q <= '0;
				len_q  <= len_c;
				if (idx_q == '0) begin
					first_q[0] <= in_data.pos_x;
					first_q[1] <= in_data.pos_y;
					first_q[2] <= in_data.pos_z;
					prev_q[0]  <= in_data.pos_x;
					prev_q[1]  <= in_data.pos_y;
					prev_q[2]  <= in_data.pos_z;
					bls_q      <= '0;
					as_q       <= '0;
				end
			end
			OP_WSTART: begin
				for (int k = 0; k < 3; k++) begin
					d_q[k]  <= dnew[k];
					wa_q[k] <= dabs[k];
					wr_q[k] <= '0;
				end
			end
			OP_WSTEP: begin
				for (int k = 0; k < 3; k++) begin
					wr_q[k] <= wn[k][REM_W-1:0];
					wa_q[k] <= {wa_q[k][VEC_W-2:0], 1'b0};
				end
			end
			OP_WEND: begin
				for (int k = 0; k < 3; k++) v_q[k] <= vnew[k];
			end
			OP_MUL_NORM, OP_MUL_DOT, OP_MUL_CSQ: begin
				// first product of a sum: start from zero, nothing pending
				if (cmd.cnt == '0) acc_q <= '0;
			end
			OP_MUL_PROD: ;
			OP_SQ_START: begin
				sv_q   <= cmd.alt ? (SINE_ONE - acc_q[SQ_W-1:0]) : acc_q[SQ_W-1:0];
				sres_q <= '0;
				sbit_q <= SQ_BIT_TOP;
			end
			OP_SQ_STEP: begin
				if (sv_q >= sq_try) begin
					sv_q   <= sv_q - sq_try;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			OP_BEND: begin
				rootc_q               <= sres_q[ROOT_W-1:0];
				wres_q.bond_length    <= sat_len(sres_q);
				wres_q.bond_valid     <= 1'b1;
				bls_q                 <= bls_q + BSUM_W'(sat_len(sres_q));
			end
			OP_DEGEN: begin
				wres_q.angle_valid <= 1'b1;
				wres_q.degenerate  <= 1'b1;
			end
			OP_COS_START: begin
				mag_q   <= mabs;
				neg_q   <= acc_q[PROD_W-1];
				clamp_q <= (mabs >= MAG_W'(prod_q));
				c_q     <= '0;
			end
			OP_COS_STEP: begin
				if (m2 >= MAG_W'(prod_q)) begin
					mag_q <= m2 - MAG_W'(prod_q);
					c_q   <= {c_q[COS_W-2:0], 1'b1};
				end else begin
					mag_q <= m2;
					c_q   <= {c_q[COS_W-2:0], 1'b0};
				end
			end
			OP_COS_END: begin
				if (clamp_q) c_q <= COS_ONE;
			end
			OP_COR_START: begin
				x_q <= $signed({2'b00, c_q});
				y_q <= $signed({1'b0, sres_q[ROOT_W-1:0]});
				z_q <= '0;
			end
			OP_COR_STEP: begin
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end
			end
			OP_AEND: begin
				wres_q.bend_angle  <= ang;
				wres_q.angle_valid <= 1'b1;
				as_q               <= as_q + ASUM_W'(ang);
			end
			OP_UPDATE: begin
				for (int k = 0; k < 3; k++) begin
					pv_q[k]   <= v_q[k];
					prev_q[k] <= p_q[k];
				end
				rootp_q <= rootc_q;
			end
			OP_EEND: begin
				wres_q.chain_done <= 1'b1;
				wres_q.end_to_end <= sat_len(sres_q);
			end
			OP_DV_START: begin
				dn_q  <= cmd.alt ? DIV_W'(as_q) : bls_q;
				den_q <= cmd.alt ? DEN_W'(len_q - 7'd2) : DEN_W'(len_q - 7'd1);
				dr_q  <= '0;
				dq_q  <= '0;
			end
			OP_DV_STEP: begin
				if (dt >= {1'b0, den_q}) begin
					dr_q <= DEN_W'(dt - {1'b0, den_q});
					dq_q <= {dq_q[DIV_W-2:0], 1'b1};
				end else begin
					dr_q <= dt[DEN_W-1:0];
					dq_q <= {dq_q[DIV_W-2:0], 1'b0};
				end
				dn_q <= {dn_q[DIV_W-2:0], 1'b0};
			end
			OP_DV_END: begin
				if (cmd.alt) wres_q.mean_bend_angle <= dq_q[ANG_W-1:0];
				else wres_q.mean_bond_length <= sat_len(SQ_W'(dq_q));
			end
			OP_PUB: out_q <= wres_q;
			default: ;
		endcase
	end

endmodule

// ===== design/chain_bond_angle_geometry_unit.sv =====
`timescale 1ns / 1ps
// Beads are taken one at a time: in_stall holds off a new bead until the
// current bead's result is published. The shared square root unit (26 steps),
// wrap lanes (25 steps), cosine divider (24), CORDIC (20) and mean divider
// (30 steps, twice) run one after the other. Results wait in an output register.
// Reset: async, active low; box 30.0, chain length 16, bead count zero.
// ----------------------------------------------------------------------------
// chain_bond_angle_geometry_unit
// Per-bead bond length, bend angle and per-chain summary of bead chains in a
// periodic box.
// ----------------------------------------------------------------------------
module chain_bond_angle_geometry_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cbag_pkg::bead_t                in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cbag_pkg::geom_t                out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cbag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbag_pkg::BOX_W-1:0]     cfg_data
);
	import cbag_pkg::*;

	cmd_t    cmd;
	status_t st;

	assign cfg_ready = 1'b1;

	cbag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	cbag_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
